@@ rtl/core/gbdt_pkg.sv @@
package gbdt_pkg;

   localparam int MaxNodesDefault  = 32;
   localparam int MaxDegreeDefault = 8;
   localparam int KeyWidthDefault  = 16;

   typedef enum logic [1:0] {
      OP_ADD_NODE = 2'd0,
      OP_ADD_EDGE = 2'd1,
      OP_BFS      = 2'd2,
      OP_DFS      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FIND_A,
      S_FIND_B,
      S_EDGE_CHECK,
      S_EDGE_WR_A,
      S_EDGE_WR_B,
      S_NODE_ADD,
      S_WALK_CLEAR,
      S_BFS_POP,
      S_BFS_KEY,
      S_BFS_NBR_RD,
      S_BFS_NBR,
      S_DFS_TOP,
      S_DFS_NBR_RD,
      S_DFS_NBR,
      S_DFS_KEY,
      S_RESULT,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take_item;
      logic       search_a;
      logic       search_b;
      logic       search_start;
      logic       search_step;
      logic       node_add;
      logic       edge_wr_a;
      logic       edge_wr_b;
      logic       walk_init;
      logic       bfs_pop;
      logic       nbr_read;
      logic       nbr_visit;
      logic       dfs_top;
      logic       dfs_pop;
      logic       key_read;
      logic       load_result;
      logic [1:0] result_status;
      logic       result_from_node;
      logic       result_last;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      op_type operation;
      logic   search_done;
      logic   search_hit;
      logic   node_full;
      logic   edge_full;
      logic   queue_empty;
      logic   nbr_more;
      logic   nbr_new;
      logic   stack_empty;
      logic   result_free;
   } stat_type;

endpackage

@@ rtl/core/graph_bfs_dfs_traversal_core.sv @@
// Keyed undirected graph with breadth-first and depth-first walks. One request
// is taken at a time; req_tready is low until the block has finished it. Adding
// a node passes through S_FIND_A, S_NODE_ADD, S_RESULT and S_FINISH before the
// block is ready again. Add edge and walks first search the stored keys one node
// per cycle. A breadth-first walk then pops each node, reads its key and scans
// its neighbour entries; a depth-first walk reads the stack top and one
// neighbour entry at a time, both through the single neighbour-memory read
// port. The controller waits in S_RESULT while an earlier response is still
// held for rsp_tready. Each request yields one response, or one per visited
// node for a walk from a stored key, with tlast on the final one.
module graph_bfs_dfs_traversal_core
   import gbdt_pkg::*;
#(
   parameter int MAX_NODES  = MaxNodesDefault,
   parameter int MAX_DEGREE = MaxDegreeDefault,
   parameter int KEY_WIDTH  = KeyWidthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // operation[1:0], key_a[KEY_WIDTH+1:2], key_b, zero fill
   input  logic [((2+2*KEY_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // node_key[KEY_WIDTH-1:0], status[KEY_WIDTH+1:KEY_WIDTH], zero fill
   output logic [((KEY_WIDTH+2+7)/8)*8-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int RW = ((KEY_WIDTH+2+7)/8)*8;

   cmd_type              cmd;
   stat_type             stat;
   logic                 busy;
   logic [KEY_WIDTH-1:0] rsp_key;
   logic [1:0]           rsp_status;

   assign req_tready = !busy;

   gbdt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_tvalid && req_tready),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   gbdt_dp #(
      .MAX_NODES  (MAX_NODES),
      .MAX_DEGREE (MAX_DEGREE),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_tdata_op ({6'd0, req_tdata[1:0]}),
      .req_key_a    (req_tdata[KEY_WIDTH+1:2]),
      .req_key_b    (req_tdata[2*KEY_WIDTH+1:KEY_WIDTH+2]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_key      (rsp_key),
      .rsp_status   (rsp_status),
      .rsp_tlast    (rsp_tlast)
   );

   assign rsp_tdata = RW'({rsp_status, rsp_key});

endmodule

@@ rtl/core/gbdt_ctrl.sv @@
module gbdt_ctrl
   import gbdt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_take,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type  state_ff, state_in;
   state_type  after_ff, after_in;
   logic       pend_last_ff, pend_last_in;
   status_type pend_status_ff, pend_status_in;
   logic       pend_node_ff, pend_node_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         after_ff       <= S_IDLE;
         pend_last_ff   <= 1'b0;
         pend_status_ff <= ST_OK;
         pend_node_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         after_ff       <= after_in;
         pend_last_ff   <= pend_last_in;
         pend_status_ff <= pend_status_in;
         pend_node_ff   <= pend_node_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      after_in       = after_ff;
      pend_last_in   = pend_last_ff;
      pend_status_in = pend_status_ff;
      pend_node_in   = pend_node_ff;
      cmd            = '0;
      busy           = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd.take_item  = 1'b1;
               pend_status_in = ST_OK;
               pend_node_in   = 1'b0;
               state_in       = S_FIND_A;
            end
         end
         S_FIND_A: begin
            if (stat.operation == OP_ADD_NODE) begin
               state_in = S_NODE_ADD;
            end else begin
               cmd.search_start = 1'b1;
               cmd.search_a     = 1'b1;
               state_in         = S_FIND_B;
            end
         end
         S_FIND_B: begin
            cmd.search_step = 1'b1;
            if (stat.search_done) begin
               if (!stat.search_hit) begin
                  pend_status_in = ST_NOT_FOUND;
                  pend_last_in   = 1'b1;
                  after_in       = S_FINISH;
                  state_in       = S_RESULT;
               end else if (stat.operation == OP_ADD_EDGE) begin
                  cmd.search_start = 1'b1;
                  cmd.search_b     = 1'b1;
                  state_in         = S_EDGE_CHECK;
               end else begin
                  state_in = S_WALK_CLEAR;
               end
            end
         end
         S_EDGE_CHECK: begin
            cmd.search_step = 1'b1;
            if (stat.search_done) begin
               if (!stat.search_hit) begin
                  pend_status_in = ST_NOT_FOUND;
                  pend_last_in   = 1'b1;
                  after_in       = S_FINISH;
                  state_in       = S_RESULT;
               end else begin
                  state_in = S_EDGE_WR_A;
               end
            end
         end
         S_EDGE_WR_A: begin
            if (stat.edge_full) begin
               pend_status_in = ST_FULL;
               pend_last_in   = 1'b1;
               after_in       = S_FINISH;
               state_in       = S_RESULT;
            end else begin
               cmd.edge_wr_a = 1'b1;
               state_in      = S_EDGE_WR_B;
            end
         end
         S_EDGE_WR_B: begin
            cmd.edge_wr_b  = 1'b1;
            pend_status_in = ST_OK;
            pend_last_in   = 1'b1;
            after_in       = S_FINISH;
            state_in       = S_RESULT;
         end
         S_NODE_ADD: begin
            if (stat.node_full) begin
               pend_status_in = ST_FULL;
            end else begin
               cmd.node_add   = 1'b1;
               pend_status_in = ST_OK;
            end
            pend_last_in = 1'b1;
            after_in     = S_FINISH;
            state_in     = S_RESULT;
         end
         S_WALK_CLEAR: begin
            cmd.walk_init = 1'b1;
            state_in = (stat.operation == OP_BFS) ? S_BFS_POP : S_DFS_KEY;
         end
         // Breadth-first: pop the queue head, scan its list, then emit its key.
         S_BFS_POP: begin
            if (stat.queue_empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.bfs_pop  = 1'b1;
               cmd.key_read = 1'b1;
               state_in     = S_BFS_KEY;
            end
         end
         S_BFS_KEY: begin
            cmd.nbr_read = 1'b1;
            state_in     = S_BFS_NBR_RD;
         end
         S_BFS_NBR_RD: begin
            state_in = S_BFS_NBR;
         end
         S_BFS_NBR: begin
            if (stat.nbr_more) begin
               cmd.nbr_visit = 1'b1;
               cmd.nbr_read  = 1'b1;
               state_in      = S_BFS_NBR_RD;
            end else begin
               // Emit the popped node once its list is queued; last if queue empty.
               pend_node_in   = 1'b1;
               pend_status_in = ST_OK;
               pend_last_in   = stat.queue_empty;
               after_in       = stat.queue_empty ? S_FINISH : S_BFS_POP;
               state_in       = S_RESULT;
            end
         end
         // Depth-first: the key of the latest visited node is held until the
         // next visit or the end of the walk shows whether it is the last one.
         S_DFS_KEY: begin
            cmd.key_read = 1'b1;
            state_in     = S_DFS_TOP;
         end
         S_DFS_TOP: begin
            if (stat.stack_empty) begin
               pend_node_in   = 1'b1;
               pend_status_in = ST_OK;
               pend_last_in   = 1'b1;
               after_in       = S_FINISH;
               state_in       = S_RESULT;
            end else begin
               cmd.dfs_top = 1'b1;
               state_in    = S_DFS_NBR_RD;
            end
         end
         S_DFS_NBR_RD: begin
            state_in = S_DFS_NBR;
         end
         S_DFS_NBR: begin
            if (!stat.nbr_more) begin
               cmd.dfs_pop = 1'b1;
               state_in    = S_DFS_TOP;
            end else if (stat.nbr_new) begin
               cmd.nbr_visit  = 1'b1;
               pend_node_in   = 1'b1;
               pend_status_in = ST_OK;
               pend_last_in   = 1'b0;
               after_in       = S_DFS_KEY;
               state_in       = S_RESULT;
            end else begin
               cmd.nbr_visit = 1'b1;
               state_in      = S_DFS_TOP;
            end
         end
         S_RESULT: begin
            if (stat.result_free) begin
               cmd.load_result      = 1'b1;
               cmd.result_status    = pend_status_ff;
               cmd.result_from_node = pend_node_ff;
               cmd.result_last      = pend_last_ff;
               state_in             = after_ff;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/gbdt_dp.sv @@
module gbdt_dp
   import gbdt_pkg::*;
#(
   parameter int MAX_NODES  = MaxNodesDefault,
   parameter int MAX_DEGREE = MaxDegreeDefault,
   parameter int KEY_WIDTH  = KeyWidthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_tdata_op,
   input  logic [KEY_WIDTH-1:0] req_key_a,
   input  logic [KEY_WIDTH-1:0] req_key_b,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [KEY_WIDTH-1:0] rsp_key,
   output logic [1:0]           rsp_status,
   output logic                 rsp_tlast
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int DW = $clog2(MAX_DEGREE + 1);
   localparam int AW = $clog2(MAX_NODES * MAX_DEGREE);

   // Memories: keys, neighbour lists, walk queue and stack.
   logic [KEY_WIDTH-1:0] key_mem [MAX_NODES];
   logic [NW-1:0]        nbr_mem [MAX_NODES*MAX_DEGREE];
   logic [NW-1:0]        queue_mem [MAX_NODES];
   logic [NW-1:0]        stack_mem [MAX_NODES];
   logic [DW-1:0]        degree_ff [MAX_NODES];
   logic [DW-1:0]        cursor_ff [MAX_NODES];
   logic [MAX_NODES-1:0] visited_ff;

   op_type               op_ff;
   logic [KEY_WIDTH-1:0] key_a_ff, key_b_ff, cmp_key_ff, key_rd_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        scan_ff;
   logic                 scan_busy_ff, hit_ff;
   logic [NW-1:0]        node_a_ff, node_b_ff, hit_node_ff;
   logic [NW-1:0]        cur_ff, nbr_ff;
   logic [DW-1:0]        pos_ff;
   logic                 pos_ok_ff;
   logic [CW-1:0]        head_ff, tail_ff, top_ff;
   logic                 out_valid_ff;
   logic [KEY_WIDTH-1:0] out_key_ff;
   logic [1:0]           out_status_ff;
   logic                 out_last_ff;

   logic [KEY_WIDTH-1:0] scan_key;
   logic                 scan_end;
   logic [NW-1:0]        scan_idx;
   logic [DW-1:0]        deg_a, deg_b;
   logic [DW:0]          deg_a_two;
   logic [AW-1:0]        nbr_wr_a_addr, nbr_wr_b_addr, nbr_rd_addr;

   assign scan_idx = scan_ff[NW-1:0];
   assign scan_key = key_mem[scan_idx];
   assign scan_end = (scan_ff >= count_ff);
   assign deg_a    = degree_ff[node_a_ff];
   assign deg_b    = degree_ff[node_b_ff];
   assign deg_a_two = {1'b0, deg_a} + (DW+1)'(2);

   // Flat neighbour-store addresses: node times list length plus position.
   assign nbr_wr_a_addr = AW'(node_a_ff * MAX_DEGREE + deg_a);
   assign nbr_wr_b_addr = AW'(node_b_ff * MAX_DEGREE + deg_b);
   assign nbr_rd_addr   = AW'(cur_ff * MAX_DEGREE + pos_ff);

   // Sequential key search, one stored node per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else if (cmd.search_start) begin
         scan_busy_ff <= 1'b1;
         hit_ff       <= 1'b0;
      end else if (cmd.search_step && scan_busy_ff) begin
         if (scan_end) begin
            scan_busy_ff <= 1'b0;
         end else if (scan_key == cmp_key_ff) begin
            scan_busy_ff <= 1'b0;
            hit_ff       <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         scan_ff    <= '0;
         cmp_key_ff <= cmd.search_a ? key_a_ff : key_b_ff;
      end else if (cmd.search_step && scan_busy_ff && !scan_end) begin
         if (scan_key == cmp_key_ff) begin
            hit_node_ff <= scan_idx;
         end else begin
            scan_ff <= scan_ff + CW'(1);
         end
      end
   end

   always_comb begin
      stat             = '0;
      stat.operation   = op_ff;
      stat.search_done = !scan_busy_ff;
      stat.search_hit  = hit_ff;
      stat.node_full   = (count_ff >= CW'(MAX_NODES));
      if (node_a_ff == node_b_ff) begin
         stat.edge_full = (deg_a_two > (DW+1)'(MAX_DEGREE));
      end else begin
         stat.edge_full = (deg_a >= DW'(MAX_DEGREE)) || (deg_b >= DW'(MAX_DEGREE));
      end
      stat.queue_empty = (head_ff == tail_ff);
      stat.nbr_more    = pos_ok_ff;
      stat.nbr_new     = !visited_ff[nbr_ff];
      stat.stack_empty = (top_ff == '0);
      stat.result_free = !out_valid_ff || rsp_tready;
   end

   // Capture the item and the found node indices.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         op_ff    <= op_type'(req_tdata_op[1:0]);
         key_a_ff <= req_key_a;
         key_b_ff <= req_key_b;
      end
      if (cmd.search_b) begin
         node_a_ff <= hit_node_ff;
      end
      if (cmd.walk_init) begin
         node_a_ff <= hit_node_ff;
      end
      if (!scan_busy_ff && hit_ff && op_ff == OP_ADD_EDGE && !cmd.search_b) begin
         node_b_ff <= hit_node_ff;
      end
   end

   // Node store and neighbour store writes.
   always_ff @(posedge clock) begin
      if (cmd.node_add) begin
         key_mem[count_ff[NW-1:0]] <= key_a_ff;
      end
      if (cmd.edge_wr_a) begin
         nbr_mem[nbr_wr_a_addr] <= node_b_ff;
      end
      if (cmd.edge_wr_b) begin
         nbr_mem[nbr_wr_b_addr] <= node_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_NODES; i++) degree_ff[i] <= '0;
      end else begin
         if (cmd.node_add) begin
            count_ff <= count_ff + CW'(1);
            degree_ff[count_ff[NW-1:0]] <= '0;
         end
         if (cmd.edge_wr_a) degree_ff[node_a_ff] <= deg_a + DW'(1);
         if (cmd.edge_wr_b) degree_ff[node_b_ff] <= deg_b + DW'(1);
      end
   end

   // Walk bookkeeping: visited marks, queue, stack and list cursor.
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         top_ff     <= '0;
         pos_ok_ff  <= 1'b0;
      end else begin
         if (cmd.walk_init) begin
            visited_ff <= {{(MAX_NODES-1){1'b0}}, 1'b1} << hit_node_ff;
            head_ff <= '0;
            if (op_ff == OP_BFS) begin
               queue_mem[0] <= hit_node_ff;
               tail_ff      <= CW'(1);
               top_ff       <= '0;
            end else begin
               stack_mem[0]          <= hit_node_ff;
               cursor_ff[hit_node_ff] <= '0;
               top_ff                <= CW'(1);
               cur_ff                <= hit_node_ff;
            end
         end
         if (cmd.bfs_pop) begin
            cur_ff  <= queue_mem[head_ff[NW-1:0]];
            head_ff <= head_ff + CW'(1);
            pos_ff  <= '0;
         end
         if (cmd.dfs_top) begin
            cur_ff      <= stack_mem[top_ff[NW-1:0] - NW'(1)];
            pos_ff      <= cursor_ff[stack_mem[top_ff[NW-1:0] - NW'(1)]];
         end
         if (cmd.dfs_pop) begin
            top_ff <= top_ff - CW'(1);
         end
         if (cmd.nbr_visit) begin
            if (op_ff == OP_BFS) begin
               pos_ff <= pos_ff + DW'(1);
               if (!visited_ff[nbr_ff] && tail_ff < CW'(MAX_NODES)) begin
                  visited_ff[nbr_ff]          <= 1'b1;
                  queue_mem[tail_ff[NW-1:0]]  <= nbr_ff;
                  tail_ff                     <= tail_ff + CW'(1);
               end
            end else begin
               cursor_ff[cur_ff] <= pos_ff + DW'(1);
               if (!visited_ff[nbr_ff] && top_ff < CW'(MAX_NODES)) begin
                  visited_ff[nbr_ff]         <= 1'b1;
                  stack_mem[top_ff[NW-1:0]]  <= nbr_ff;
                  cursor_ff[nbr_ff]          <= '0;
                  top_ff                     <= top_ff + CW'(1);
                  cur_ff                     <= nbr_ff;
               end
            end
         end
         // Neighbour fetch: the entry is registered during the read-wait state.
         if (cmd.nbr_read || cmd.dfs_top) begin
            pos_ok_ff <= 1'b0;
         end else begin
            pos_ok_ff <= (pos_ff < degree_ff[cur_ff]) && (pos_ff < DW'(MAX_DEGREE));
            nbr_ff    <= nbr_mem[nbr_rd_addr];
         end
      end
   end

   // Key read for the node about to be emitted.
   always_ff @(posedge clock) begin
      if (cmd.key_read) begin
         if (cmd.bfs_pop) begin
            key_rd_ff <= key_mem[queue_mem[head_ff[NW-1:0]]];
         end else begin
            key_rd_ff <= key_mem[cur_ff];
         end
      end
   end

   // Output register; a transaction leaves when the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_key_ff    <= cmd.result_from_node ? key_rd_ff : key_a_ff;
         out_status_ff <= cmd.result_status;
         out_last_ff   <= cmd.result_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_key    = out_key_ff;
   assign rsp_status = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   unused_check: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten while pending");
   count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count overflow");
   queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   import gbdt_pkg::*;

   localparam int NODES = 32;
   localparam int DEGREE = 8;
   localparam int REQ_W = 40;
   localparam int RSP_W = 24;
   localparam int CYCLE_LIMIT = 1000000;

   // Packed so that operation lands in the lowest bits of tdata.
   typedef struct packed {
      logic [15:0] key_b;
      logic [15:0] key_a;
      op_type      operation;
   } graph_req_t;

   typedef struct packed {
      logic [15:0] node_key;
      status_type  status;
      logic        last;
   } graph_rsp_t;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;

   graph_bfs_dfs_traversal_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // Shadow copy of the graph store.
   logic [15:0] graph_keys [NODES];
   int          graph_count;
   int          graph_nbr [NODES][DEGREE];
   int          graph_deg [NODES];

   graph_req_t pending_reqs [$];
   graph_rsp_t expected_visits [$];
   int  error_count;
   int  cycle_count;
   bit  stimulus_done;
   bit  hold_rsp;     // long receiver hold-off request
   bit  drain_wait;   // sender pause until results drain
   int  drain_marker [$];

   function automatic int lookup_key(logic [15:0] key);
      for (int i = 0; i < graph_count; i++)
         if (graph_keys[i] == key) return i;
      return -1;
   endfunction

   function automatic void push_visit(logic [15:0] key, status_type st, logic lst);
      graph_rsp_t r;
      r.node_key = key;
      r.status = st;
      r.last = lst;
      expected_visits = {expected_visits, r};
   endfunction

   // Computes the results of one accepted request and updates the shadow graph.
   function automatic void predict_request(graph_req_t rq);
      int a, b, top, n, i, m;
      bit seen [NODES];
      int order [$];
      int fifo [$];
      int stk_node [NODES];
      int stk_pos [NODES];
      case (rq.operation)
         OP_ADD_NODE: begin
            if (graph_count >= NODES) begin
               push_visit(rq.key_a, ST_FULL, 1'b1);
            end else begin
               graph_keys[graph_count] = rq.key_a;
               graph_deg[graph_count] = 0;
               graph_count++;
               push_visit(rq.key_a, ST_OK, 1'b1);
            end
         end
         OP_ADD_EDGE: begin
            a = lookup_key(rq.key_a);
            b = lookup_key(rq.key_b);
            if (a < 0 || b < 0) begin
               push_visit(rq.key_a, ST_NOT_FOUND, 1'b1);
            end else if ((a == b && graph_deg[a] + 2 > DEGREE) ||
                         (a != b && (graph_deg[a] >= DEGREE || graph_deg[b] >= DEGREE))) begin
               push_visit(rq.key_a, ST_FULL, 1'b1);
            end else begin
               graph_nbr[a][graph_deg[a]] = b;
               graph_deg[a] = graph_deg[a] + 1;
               graph_nbr[b][graph_deg[b]] = a;
               graph_deg[b] = graph_deg[b] + 1;
               push_visit(rq.key_a, ST_OK, 1'b1);
            end
         end
         default: begin
            a = lookup_key(rq.key_a);
            if (a < 0) begin
               push_visit(rq.key_a, ST_NOT_FOUND, 1'b1);
            end else begin
               foreach (seen[j]) seen[j] = 0;
               seen[a] = 1;
               if (rq.operation == OP_BFS) begin
                  fifo = {fifo, a};
                  while (fifo.size() > 0) begin
                     n = fifo.pop_front();
                     order = {order, n};
                     for (i = 0; i < graph_deg[n]; i++) begin
                        m = graph_nbr[n][i];
                        if (!seen[m]) begin
                           seen[m] = 1;
                           fifo = {fifo, m};
                        end
                     end
                  end
               end else begin
                  order = {order, a};
                  stk_node[0] = a;
                  stk_pos[0] = 0;
                  top = 1;
                  while (top > 0) begin
                     n = stk_node[top-1];
                     i = stk_pos[top-1];
                     if (i >= graph_deg[n]) begin
                        top--;
                     end else begin
                        stk_pos[top-1] = i + 1;
                        m = graph_nbr[n][i];
                        if (!seen[m]) begin
                           seen[m] = 1;
                           order = {order, m};
                           stk_node[top] = m;
                           stk_pos[top] = 0;
                           top++;
                        end
                     end
                  end
               end
               foreach (order[j])
                  push_visit(graph_keys[order[j]], ST_OK, j == order.size() - 1);
            end
         end
      endcase
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Key pool keeps lookups hitting most of the time.
   logic [15:0] key_pool [$];

   function automatic logic [15:0] pick_key();
      if (key_pool.size() > 0 && $urandom_range(0, 9) != 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return 16'($urandom);
   endfunction

   function automatic void queue_req(op_type op, logic [15:0] ka, logic [15:0] kb);
      graph_req_t r;
      r.operation = op;
      r.key_a = ka;
      r.key_b = kb;
      pending_reqs = {pending_reqs, r};
      if (op == OP_ADD_NODE) key_pool = {key_pool, ka};
   endfunction

   // Stimulus: one graph run is filled, then a second batch after a drain.
   initial begin
      int k;
      // Walks and edges on an empty graph miss.
      queue_req(OP_BFS, 16'h0000, 16'h0000);
      queue_req(OP_DFS, 16'hFFFF, 16'h0000);
      queue_req(OP_ADD_EDGE, 16'h0001, 16'h0002);
      queue_req(OP_ADD_NODE, 16'h0000, 16'hFFFF);
      queue_req(OP_ADD_NODE, 16'hFFFF, 16'h0000);
      queue_req(OP_ADD_NODE, 16'h5A5A, 16'h0000);
      queue_req(OP_ADD_NODE, 16'hFFFF, 16'h0000);   // duplicate key
      queue_req(OP_ADD_EDGE, 16'h0000, 16'hFFFF);
      queue_req(OP_ADD_EDGE, 16'h5A5A, 16'h5A5A);   // self loop
      queue_req(OP_ADD_EDGE, 16'hFFFF, 16'h5A5A);
      queue_req(OP_ADD_EDGE, 16'h0000, 16'h1234);   // one end missing
      queue_req(OP_BFS, 16'h0000, 16'h0000);
      queue_req(OP_DFS, 16'h0000, 16'hFFFF);
      // Fill one neighbour list up to its limit.
      for (k = 0; k < 5; k++) queue_req(OP_ADD_EDGE, 16'h0000, 16'h5A5A);
      queue_req(OP_ADD_EDGE, 16'h5A5A, 16'h5A5A);   // self loop, full
      queue_req(OP_DFS, 16'h5A5A, 16'h0000);
      queue_req(OP_BFS, 16'hFFFF, 16'h0000);
      queue_req(OP_BFS, 16'h0BAD, 16'h0000);        // walk start missing
      wait (pending_reqs.size() == 0);
      drain_marker = {drain_marker, 1};
      // Random part: mostly adds early, then edges and walks on known keys.
      for (k = 0; k < 110; k++) begin
         int sel;
         sel = $urandom_range(0, 9);
         if (k < 40 ? sel < 6 : sel < 1)
            queue_req(OP_ADD_NODE, 16'($urandom), 16'($urandom));
         else if (sel < 6)
            queue_req(OP_ADD_EDGE, pick_key(), pick_key());
         else
            queue_req(sel < 8 ? OP_BFS : OP_DFS, pick_key(), 16'($urandom));
         if (k == 60) begin
            // Overflow the node store once.
            for (int j = 0; j < 34; j++) queue_req(OP_ADD_NODE, 16'($urandom), 16'h0);
         end
      end
      stimulus_done = 1'b1;
   end

   // Driver.
   int gap_left;
   int accepted;
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      gap_left = 0;
      accepted = 0;
      drain_wait = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request(graph_req_t'(req_tdata[33:0]));
            accepted++;
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (accepted == 30) gap_left = 0;
         end
         if (drain_marker.size() > 0 && !(req_tvalid && !req_tready)) begin
            drain_wait = 1'b1;
            void'(drain_marker.pop_front());
         end
         if (drain_wait && expected_visits.size() == 0 && !(req_tvalid && req_tready))
            drain_wait = 1'b0;
         if (req_tvalid && !req_tready) begin
            // Hold the current transaction.
         end else if (gap_left > 0 || drain_wait || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_W'(pending_reqs.pop_front());
         end
      end
   end

   // Long receiver hold-off while the sender keeps offering.
   initial begin
      hold_rsp = 1'b0;
      wait (accepted >= 25);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Monitor and result checker.
   int stall_left;
   initial begin
      rsp_tready = 1'b0;
      stall_left = 0;
      error_count = 0;
   end

   always @(posedge clock) begin
      graph_rsp_t got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.node_key = rsp_tdata[15:0];
            got.status = status_type'(rsp_tdata[17:16]);
            got.last = rsp_tlast;
            if (expected_visits.size() == 0) begin
               $display("%0t: unexpected result key=%h status=%0d last=%0b",
                        $time, got.node_key, got.status, got.last);
               error_count++;
            end else begin
               want = expected_visits.pop_front();
               if (got.node_key !== want.node_key || got.status !== want.status ||
                   got.last !== want.last || rsp_tdata[23:18] !== 6'd0) begin
                  $display("%0t: expected key=%h st=%0d last=%0b, actual key=%h st=%0d last=%0b",
                           $time, want.node_key, want.status, want.last,
                           got.node_key, got.status, got.last);
                  error_count++;
               end
            end
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Run end and timeout.
   initial begin
      cycle_count = 0;
      fork
         begin
            wait (stimulus_done && pending_reqs.size() == 0 && !req_tvalid &&
                  expected_visits.size() == 0);
            repeat (200) @(posedge clock);
         end
         begin
            while (cycle_count < CYCLE_LIMIT) begin
               @(posedge clock);
               cycle_count++;
            end
            error_count++;
         end
      join_any
      if (error_count == 0 && expected_visits.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

@@ graph_bfs_dfs_traversal_core.f @@
rtl/core/gbdt_pkg.sv
rtl/core/gbdt_ctrl.sv
rtl/core/gbdt_dp.sv
rtl/core/graph_bfs_dfs_traversal_core.sv
verif/tb_top.sv
